[hdl/ohtab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_pkg
// Shared constants, types and helpers for the object id hash table.
// ----------------------------------------------------------------------------
package ohtab_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 11;
    localparam int KEY_W       = 31;
    localparam int ENTRY_W     = 10;
    localparam int ID_W        = 32;

    // slot row: used, entry, id1, id0, id2, manager
    localparam int ROW_W       = 1 + ENTRY_W + 4 * ID_W;
    localparam int ROW_USED    = ROW_W - 1;
    localparam int ROW_ENT_LSB = 4 * ID_W;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(617);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_FOUND = 2'd1,
        RES_MISS  = 2'd2,
        RES_FULL  = 2'd3
    } res_code_t;

    typedef struct packed {
        logic      load;
        logic      clr_step;
        logic      hash_step;
        logic      probe_next;
        logic      slot_wr;
        logic      res_valid;
        res_code_t res_code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       clr_last;
        logic       div_last;
        logic       slot_used;
        logic       slot_match;
        logic       probe_last;
    } sts_t;

    // magnitude of a signed word, most negative value saturates
    function automatic logic [KEY_W-1:0] magnitude(input logic [ID_W-1:0] w);
        logic [ID_W-1:0] n;
        begin
            n = ~w + 32'd1;
            if (w == 32'h8000_0000)
                magnitude = 31'h7FFF_FFFF;
            else if (w[ID_W-1])
                magnitude = n[KEY_W-1:0];
            else
                magnitude = w[KEY_W-1:0];
        end
    endfunction

endpackage

[hdl/ohtab_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ohtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ohtab_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_ctrl
// Sequencer: clearing pass, bit-serial hash, linear probe loop.
// ----------------------------------------------------------------------------
module ohtab_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        action,
    input  ohtab_pkg::sts_t   sts,
    output ohtab_pkg::cmd_t   cmd,
    output logic              busy
);

    ohtab_pkg::state_t state_reg, state_next;
    logic init_reg, init_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ohtab_pkg::ST_CLEAR;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        cmd        = '0;
        cmd.res_code = ohtab_pkg::RES_DONE;
        case (state_reg)
            ohtab_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (action)
                        ohtab_pkg::ACT_CLEAR:  state_next = ohtab_pkg::ST_CLEAR;
                        ohtab_pkg::ACT_INSERT: state_next = ohtab_pkg::ST_HASH;
                        ohtab_pkg::ACT_LOOKUP: state_next = ohtab_pkg::ST_HASH;
                        default:
                        begin
                            // unused code: answer at once
                            cmd.res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ohtab_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next    = ohtab_pkg::ST_IDLE;
                    init_next     = 1'b0;
                    cmd.res_valid = !init_reg;
                end
            end
            ohtab_pkg::ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.div_last)
                    state_next = ohtab_pkg::ST_READ;
            end
            ohtab_pkg::ST_READ:
            begin
                state_next = ohtab_pkg::ST_CHECK;
            end
            ohtab_pkg::ST_CHECK:
            begin
                state_next = ohtab_pkg::ST_IDLE;
                if (sts.action == ohtab_pkg::ACT_INSERT)
                begin
                    if (!sts.slot_used)
                    begin
                        cmd.slot_wr   = 1'b1;
                        cmd.res_valid = 1'b1;
                    end
                    else if (sts.probe_last)
                    begin
                        cmd.res_valid = 1'b1;
                        cmd.res_code  = ohtab_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = ohtab_pkg::ST_READ;
                    end
                end
                else
                begin
                    if (!sts.slot_used || (sts.probe_last && !sts.slot_match))
                    begin
                        cmd.res_valid = 1'b1;
                        cmd.res_code  = ohtab_pkg::RES_MISS;
                    end
                    else if (sts.slot_match)
                    begin
                        cmd.res_valid = 1'b1;
                        cmd.res_code  = ohtab_pkg::RES_FOUND;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = ohtab_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ohtab_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ohtab_pkg::ST_IDLE);

endmodule

[hdl/ohtab_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_dp
// Datapath: key capture, restoring modulo, probe index, slot RAM, result.
// ----------------------------------------------------------------------------
module ohtab_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ohtab_pkg::cmd_t                     cmd,
    output ohtab_pkg::sts_t                     sts,
    input  logic                                cfg_we,
    input  logic [ohtab_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic [1:0]                          action,
    input  logic signed [ohtab_pkg::ID_W-1:0]   obj_id_0,
    input  logic signed [ohtab_pkg::ID_W-1:0]   obj_id_1,
    input  logic signed [ohtab_pkg::ID_W-1:0]   obj_id_2,
    input  logic signed [ohtab_pkg::ID_W-1:0]   manager_id,
    input  logic [ohtab_pkg::ENTRY_W-1:0]       entry_number,
    output logic                                done,
    output logic                                found,
    output logic [ohtab_pkg::ENTRY_W-1:0]       entry_out,
    output logic [1:0]                          status
);

    logic [ohtab_pkg::SIZE_W-1:0]    slot_count_reg;
    logic [1:0]                      action_reg;
    logic [ohtab_pkg::ID_W-1:0]      id0_reg, id1_reg, id2_reg, mgr_reg;
    logic [ohtab_pkg::ENTRY_W-1:0]   entry_reg;
    logic [ohtab_pkg::KEY_W-1:0]     key_reg;
    logic [ohtab_pkg::SIZE_W-1:0]    size_reg;
    logic [ohtab_pkg::IDX_W-1:0]     idx_reg;
    logic [ohtab_pkg::SIZE_W-1:0]    cnt_reg;
    logic                            done_reg, found_reg;
    logic [ohtab_pkg::ENTRY_W-1:0]   entry_out_reg;
    logic [1:0]                      status_reg;

    logic [ohtab_pkg::KEY_W-1:0]     mag0, mag1, mag2;
    logic [ohtab_pkg::KEY_W-1:0]     key_next;
    logic [ohtab_pkg::SIZE_W-1:0]    size_next;
    logic [ohtab_pkg::SIZE_W-1:0]    trial;
    logic [ohtab_pkg::IDX_W-1:0]     rem_next;
    logic [ohtab_pkg::SIZE_W-1:0]    idx_inc;
    logic [ohtab_pkg::ROW_W-1:0]     wdata, rdata;

    always_comb
    begin
        mag0 = ohtab_pkg::magnitude(obj_id_0);
        mag1 = ohtab_pkg::magnitude(obj_id_1);
        mag2 = ohtab_pkg::magnitude(obj_id_2);
        key_next = {mag2[6:0], 24'd0}
                 | {7'd0, mag1[7:0], 16'd0}
                 | mag0;
        if (slot_count_reg == '0)
            size_next = ohtab_pkg::SIZE_W'(1);
        else if (slot_count_reg > ohtab_pkg::SIZE_W'(ohtab_pkg::TABLE_DEPTH))
            size_next = ohtab_pkg::SIZE_W'(ohtab_pkg::TABLE_DEPTH);
        else
            size_next = slot_count_reg;
        // one restoring step; remainder stays below size
        trial = {idx_reg, key_reg[ohtab_pkg::KEY_W-1]};
        if (trial >= size_reg)
            rem_next = ohtab_pkg::IDX_W'(trial - size_reg);
        else
            rem_next = trial[ohtab_pkg::IDX_W-1:0];
        idx_inc = {1'b0, idx_reg} + ohtab_pkg::SIZE_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= ohtab_pkg::SIZE_RESET;
            action_reg     <= '0;
            size_reg       <= ohtab_pkg::SIZE_RESET;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                slot_count_reg <= cfg_wdata;
            if (cmd.load)
            begin
                action_reg <= action;
                size_reg   <= size_next;
                idx_reg    <= '0;
                cnt_reg    <= '0;
            end
            else if (cmd.clr_step)
                idx_reg <= idx_reg + ohtab_pkg::IDX_W'(1);
            else if (cmd.hash_step)
            begin
                idx_reg <= rem_next;
                if (sts.div_last)
                    cnt_reg <= '0;
                else
                    cnt_reg <= cnt_reg + ohtab_pkg::SIZE_W'(1);
            end
            else if (cmd.probe_next)
            begin
                idx_reg <= (idx_inc == size_reg) ? '0 : idx_inc[ohtab_pkg::IDX_W-1:0];
                cnt_reg <= cnt_reg + ohtab_pkg::SIZE_W'(1);
            end
            done_reg <= cmd.res_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id0_reg   <= obj_id_0;
            id1_reg   <= obj_id_1;
            id2_reg   <= obj_id_2;
            mgr_reg   <= manager_id;
            entry_reg <= entry_number;
            key_reg   <= key_next;
        end
        else if (cmd.hash_step)
            key_reg <= {key_reg[ohtab_pkg::KEY_W-2:0], 1'b0};
        if (cmd.res_valid)
        begin
            case (cmd.res_code)
                ohtab_pkg::RES_FOUND:
                begin
                    found_reg     <= 1'b1;
                    entry_out_reg <= rdata[ohtab_pkg::ROW_USED-1:ohtab_pkg::ROW_ENT_LSB];
                    status_reg    <= ohtab_pkg::STATUS_DONE;
                end
                ohtab_pkg::RES_MISS:
                begin
                    found_reg     <= 1'b0;
                    entry_out_reg <= '0;
                    status_reg    <= ohtab_pkg::STATUS_MISS;
                end
                ohtab_pkg::RES_FULL:
                begin
                    found_reg     <= 1'b0;
                    entry_out_reg <= '0;
                    status_reg    <= ohtab_pkg::STATUS_FULL;
                end
                default:
                begin
                    found_reg     <= 1'b0;
                    entry_out_reg <= '0;
                    status_reg    <= ohtab_pkg::STATUS_DONE;
                end
            endcase
        end
    end

    assign wdata = cmd.clr_step ? '0
                 : {1'b1, entry_reg, id1_reg, id0_reg, id2_reg, mgr_reg};

    ohtab_ram #(
        .WIDTH (ohtab_pkg::ROW_W),
        .DEPTH (ohtab_pkg::TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (cmd.clr_step | cmd.slot_wr),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.action     = action_reg;
        sts.clr_last   = (idx_reg == ohtab_pkg::IDX_W'(ohtab_pkg::TABLE_DEPTH - 1));
        sts.div_last   = (cnt_reg == ohtab_pkg::SIZE_W'(ohtab_pkg::KEY_W - 1));
        sts.slot_used  = rdata[ohtab_pkg::ROW_USED];
        sts.slot_match = (rdata[ohtab_pkg::ROW_ENT_LSB-1:0]
                          == {id1_reg, id0_reg, id2_reg, mgr_reg});
        sts.probe_last = ((cnt_reg + ohtab_pkg::SIZE_W'(1)) == size_reg);
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign entry_out = entry_out_reg;
    assign status    = status_reg;

endmodule

[hdl/object_id_hash_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_id_hash_table_core
// Open-addressed key-to-entry table with linear probing.
// ----------------------------------------------------------------------------
// Raise start while busy is low to hand over one beat: action (0 clear,
// 1 insert, 2 look up), the key (three object id words and a manager id)
// and, for an insert, the entry number. Exactly one result beat follows,
// shown for a single cycle with done high; the receiver cannot stall it.
// A clear keeps busy high while it writes every slot row, one slot row per
// cycle. Insert and lookup first run a bit-serial restoring modulo of the
// 31-bit key by the slot count, then probe slot by slot (one slot RAM read
// plus its compare) until a slot decides or all slots below the slot count
// have been probed. The result beat shows in the first cycle with busy low,
// and the next beat may be taken in that cycle. Action 3 leaves busy low and
// answers in the next cycle. After reset the block runs a clearing pass over
// every slot row with busy high before the first beat.
// The slot count may be written through cfg_we/cfg_wdata only while idle; it
// is sampled when a beat is taken (0 acts as 1, above 1024 acts as 1024).
// ----------------------------------------------------------------------------
module object_id_hash_table_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [ohtab_pkg::SIZE_W-1:0]        cfg_wdata,
    input  logic [1:0]                          action,
    input  logic signed [ohtab_pkg::ID_W-1:0]   obj_id_0,
    input  logic signed [ohtab_pkg::ID_W-1:0]   obj_id_1,
    input  logic signed [ohtab_pkg::ID_W-1:0]   obj_id_2,
    input  logic signed [ohtab_pkg::ID_W-1:0]   manager_id,
    input  logic [ohtab_pkg::ENTRY_W-1:0]       entry_number,
    output logic                                done,
    output logic                                found,
    output logic [ohtab_pkg::ENTRY_W-1:0]       entry_out,
    output logic [1:0]                          status
);

    // command and status between sequencer and datapath
    ohtab_pkg::cmd_t cmd;
    ohtab_pkg::sts_t sts;

    // sequencer: clear pass, modulo loop, probe loop
    ohtab_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath: size register, key regs, divider, slot RAM, result regs
    ohtab_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .action       (action),
        .obj_id_0     (obj_id_0),
        .obj_id_1     (obj_id_1),
        .obj_id_2     (obj_id_2),
        .manager_id   (manager_id),
        .entry_number (entry_number),
        .done         (done),
        .found        (found),
        .entry_out    (entry_out),
        .status       (status)
    );

endmodule

[hdl/ohtab_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohtab_checker
// Port-level checks on the hash table core.
// ----------------------------------------------------------------------------
module ohtab_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          found,
    input logic [ohtab_pkg::ENTRY_W-1:0] entry_out,
    input logic [1:0]                    status
);

    // accepted beat either starts work or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat left no trace");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ohtab_pkg::STATUS_DONE))
        else $error("found with non-done status");

    a_miss_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (entry_out == '0))
        else $error("entry_out set without a match");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ohtab_pkg::STATUS_DONE || status == ohtab_pkg::STATUS_MISS
                  || status == ohtab_pkg::STATUS_FULL))
        else $error("unused status code");

endmodule

bind object_id_hash_table_core ohtab_checker u_ohtab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .found     (found),
    .entry_out (entry_out),
    .status    (status)
);
